// ----- hw/rtl/tkvp_pkg.sv -----
// Package for the telemetry key=value parser: types and constants, and the
// per-byte parsing functions used by the parser core.
// No dependencies.
`timescale 1ns / 1ps

package tkvp_pkg;

   localparam int HDR_MAX_CHARS = 4;
   localparam int HDR_LIM       = (HDR_MAX_CHARS < 4) ? HDR_MAX_CHARS : 4;

   localparam logic [7:0] CH_BAR   = 8'h7C;
   localparam logic [7:0] CH_EQ    = 8'h3D;
   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_DOT   = 8'h2E;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;

   localparam logic [31:0] KEY_V    = 32'h0000_0076;
   localparam logic [31:0] KEY_SEQ  = 32'h0071_6573;
   localparam logic [31:0] KEY_DIST = 32'h7473_6964;
   localparam logic [31:0] KEY_BAT  = 32'h0074_6162;
   localparam logic [31:0] KEY_CHG  = 32'h0067_6863;

   localparam logic [32:0] NUM_CAP = 33'h1_0000_0000;

   // Configuration register indexes.
   localparam logic [2:0] REG_REQ_HDR  = 3'd0;
   localparam logic [2:0] REG_HDR_TEXT = 3'd1;
   localparam logic [2:0] REG_HDR_LEN  = 3'd2;
   localparam logic [2:0] REG_EXP_VER  = 3'd3;
   localparam logic [2:0] REG_REQ_VER  = 3'd4;
   localparam logic [2:0] REG_EN_MASK  = 3'd5;
   localparam logic [2:0] REG_RQ_MASK  = 3'd6;

   // Reject reason codes.
   localparam logic [3:0] RSN_NONE      = 4'd0;
   localparam logic [3:0] RSN_HEADER    = 4'd1;
   localparam logic [3:0] RSN_VERSION   = 4'd2;
   localparam logic [3:0] RSN_NO_VER    = 4'd3;
   localparam logic [3:0] RSN_NO_SEQ    = 4'd4;
   localparam logic [3:0] RSN_DISTANCE  = 4'd8;
   localparam logic [3:0] RSN_BATTERY   = 4'd9;

   // Number scanner phases.
   localparam logic [1:0] NUM_LEAD = 2'd0;
   localparam logic [1:0] NUM_INT  = 2'd1;
   localparam logic [1:0] NUM_FRAC = 2'd2;
   localparam logic [1:0] NUM_STOP = 2'd3;

   typedef struct packed {
      logic        req_hdr;
      logic [31:0] hdr_text;
      logic [2:0]  hdr_len;
      logic [15:0] exp_ver;
      logic        req_ver;
      logic [3:0]  en_mask;
      logic [3:0]  rq_mask;
   } cfg_type;

   typedef struct packed {
      logic        in_value;
      logic        started;
      logic [3:0]  hprog;
      logic [3:0]  pblank;
      logic        hpbad;
      logic        hbad;
      logic [31:0] key;
      logic [2:0]  kcnt;
      logic        kbad;
      logic        kblank;
      logic [1:0]  nphase;
      logic [32:0] acc;
      logic [9:0]  frac;
      logic [1:0]  fcnt;
      logic        neg;
      logic        inz;
      logic        anz;
   } field_type;

   typedef struct packed {
      logic            any_seen;
      logic            ffp;
      logic [3:0]      early;
      logic [4:0]      found;
      logic            chg;
      logic [3:0][31:0] caps;
      logic            dneg;
      logic            bnp;
      field_type       fld;
   } pkt_type;

   // Result item, last member in the lowest bits.
   typedef struct packed {
      logic        charging_flag;
      logic        charging_found;
      logic [31:0] battery_millivolts;
      logic        battery_found;
      logic [31:0] distance_hundredths;
      logic        distance_found;
      logic [31:0] sequence_value;
      logic        sequence_found;
      logic [31:0] version_value;
      logic        version_found;
      logic [3:0]  reject_reason;
      logic        accepted;
   } rsp_type;

   localparam field_type FIELD_CLEAR = '0;

   function automatic pkt_type pkt_clear();
      pkt_type r;
      r     = '0;
      r.ffp = 1'b1;
      return r;
   endfunction

   function automatic logic is_blank(input logic [7:0] c);
      return (c == 8'd32) || (c >= 8'd9 && c <= 8'd13);
   endfunction

   function automatic logic [2:0] hdr_len_eff(input cfg_type cfg);
      return (cfg.hdr_len > 3'(HDR_LIM)) ? 3'(HDR_LIM) : cfg.hdr_len;
   endfunction

   function automatic logic hdr_ok(input cfg_type cfg, input logic [4:0] pos,
                                   input logic [7:0] c);
      logic [31:0] sh;
      sh = cfg.hdr_text >> {pos[1:0], 3'b000};
      if (pos >= {2'b00, hdr_len_eff(cfg)}) return 1'b0;
      return sh[7:0] == c;
   endfunction

   function automatic logic [31:0] sat32(input logic [42:0] mag, input logic neg);
      logic [31:0] low;
      low = mag[31:0];
      if (neg) begin
         if (mag >= 43'h8000_0000) return 32'h8000_0000;
         return 32'd0 - low;
      end
      if (mag > 43'h7FFF_FFFF) return 32'h7FFF_FFFF;
      return low;
   endfunction

   function automatic logic [9:0] frac_weight(input logic [1:0] n);
      unique case (n)
         2'd0:    return 10'd100;
         2'd1:    return 10'd10;
         default: return 10'd1;
      endcase
   endfunction

   function automatic field_type header_byte(input field_type f, input cfg_type cfg,
                                             input logic [7:0] c);
      field_type   r;
      logic [4:0]  pos;
      logic [4:0]  sum;
      r   = f;
      pos = {1'b0, f.hprog} + {1'b0, f.pblank};
      sum = pos + 5'd1;
      if (is_blank(c)) begin
         if (f.started) begin
            if (!hdr_ok(cfg, pos, c)) r.hpbad = 1'b1;
            if (f.pblank != 4'd15) r.pblank = f.pblank + 4'd1;
         end
      end else begin
         r.started = 1'b1;
         if (f.hpbad || !hdr_ok(cfg, pos, c)) r.hbad = 1'b1;
         r.hprog  = (sum > 5'd15) ? 4'd15 : sum[3:0];
         r.pblank = 4'd0;
         r.hpbad  = 1'b0;
      end
      return r;
   endfunction

   function automatic field_type key_byte(input field_type f, input logic [7:0] c);
      field_type r;
      r = f;
      if (is_blank(c)) begin
         if (f.started) r.kblank = 1'b1;
      end else begin
         r.started = 1'b1;
         if (f.kblank || f.kcnt[2]) begin
            r.kbad = 1'b1;
         end else begin
            r.key  = f.key | ({24'd0, c} << {f.kcnt[1:0], 3'b000});
            r.kcnt = f.kcnt + 3'd1;
         end
      end
      return r;
   endfunction

   function automatic field_type value_byte(input field_type f, input logic [7:0] c);
      field_type   r;
      logic        digit;
      logic [3:0]  d;
      logic [1:0]  ph;
      logic [36:0] prod;
      r     = f;
      digit = (c >= CH_ZERO) && (c <= CH_NINE);
      d     = c[3:0];
      ph    = f.nphase;
      prod  = {1'b0, f.acc, 3'b000} + {3'b000, f.acc, 1'b0} + {33'd0, d};
      if (ph == NUM_LEAD) begin
         if (is_blank(c)) return r;
         ph       = NUM_INT;
         r.nphase = NUM_INT;
         if (c == CH_PLUS || c == CH_MINUS) begin
            r.neg = (c == CH_MINUS);
            return r;
         end
      end
      if (ph == NUM_INT) begin
         if (digit) begin
            r.acc = (prod > {4'd0, NUM_CAP}) ? NUM_CAP : prod[32:0];
            if (d != 4'd0) begin
               r.inz = 1'b1;
               r.anz = 1'b1;
            end
         end else if (c == CH_DOT) begin
            r.nphase = NUM_FRAC;
         end else begin
            r.nphase = NUM_STOP;
         end
      end else if (ph == NUM_FRAC) begin
         if (digit) begin
            if (f.fcnt != 2'd3) begin
               r.frac = f.frac + 10'(frac_weight(f.fcnt) * {6'd0, d});
               r.fcnt = f.fcnt + 2'd1;
            end
            if (d != 4'd0) r.anz = 1'b1;
         end else begin
            r.nphase = NUM_STOP;
         end
      end
      return r;
   endfunction

   function automatic pkt_type close_field(input pkt_type p, input cfg_type cfg);
      pkt_type     r;
      field_type   f;
      logic [31:0] ival;
      logic [20:0] tenth;
      logic [42:0] dmag;
      logic [42:0] bmag;
      r     = p;
      f     = p.fld;
      ival  = sat32({10'd0, f.acc}, f.neg);
      // Multiply by 205 and drop 11 bits: the fraction in hundredths, exact below 1029.
      tenth = {11'd0, f.frac} * 21'd205;
      dmag  = {10'd0, f.acc} * 43'd100 + {36'd0, tenth[17:11]};
      bmag  = {10'd0, f.acc} * 43'd1000 + {33'd0, f.frac};
      if (p.ffp) begin
         r.ffp = 1'b0;
         if (cfg.req_hdr && (f.hbad || f.hprog != {1'b0, hdr_len_eff(cfg)}))
            r.early = RSN_HEADER;
      end else if (f.in_value && !f.kbad) begin
         if (f.kcnt == 3'd1 && f.key == KEY_V) begin
            r.found[0] = 1'b1;
            r.caps[0]  = ival;
            if (ival != {16'd0, cfg.exp_ver}) r.early = RSN_VERSION;
         end else if (f.kcnt == 3'd3 && f.key == KEY_SEQ && cfg.en_mask[0]) begin
            r.found[1] = 1'b1;
            r.caps[1]  = ival;
         end else if (f.kcnt == 3'd4 && f.key == KEY_DIST && cfg.en_mask[1]) begin
            r.found[2] = 1'b1;
            r.caps[2]  = sat32(dmag, f.neg);
            r.dneg     = f.neg && f.anz;
         end else if (f.kcnt == 3'd3 && f.key == KEY_BAT && cfg.en_mask[2]) begin
            r.found[3] = 1'b1;
            r.caps[3]  = sat32(bmag, f.neg);
            r.bnp      = f.neg || !f.anz;
         end else if (f.kcnt == 3'd3 && f.key == KEY_CHG && cfg.en_mask[3]) begin
            r.found[4] = 1'b1;
            r.chg      = f.inz;
         end
      end
      r.fld = FIELD_CLEAR;
      return r;
   endfunction

   function automatic pkt_type take_byte(input pkt_type p, input cfg_type cfg,
                                         input logic [7:0] c);
      pkt_type r;
      r = p;
      if (c == CH_BAR) begin
         r = close_field(p, cfg);
      end else if (p.ffp) begin
         r.fld = header_byte(p.fld, cfg, c);
      end else if (!p.fld.in_value) begin
         if (c == CH_EQ) begin
            r.fld.in_value = 1'b1;
            r.fld.started  = 1'b0;
         end else begin
            r.fld = key_byte(p.fld, c);
         end
      end else begin
         r.fld = value_byte(p.fld, c);
      end
      return r;
   endfunction

endpackage

// ----- hw/rtl/tkvp_csr.sv -----
// Configuration registers of the telemetry parser.
// Depends on tkvp_pkg.
`timescale 1ns / 1ps

module tkvp_csr (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_we,
   input  logic [2:0]        csr_index,
   input  logic [31:0]       csr_wdata,
   output tkvp_pkg::cfg_type cfg
);
   import tkvp_pkg::*;

   cfg_type cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.req_hdr  <= 1'b1;
         cfg_ff.hdr_text <= 32'd21332;
         cfg_ff.hdr_len  <= 3'd2;
         cfg_ff.exp_ver  <= 16'd1;
         cfg_ff.req_ver  <= 1'b1;
         cfg_ff.en_mask  <= 4'hF;
         cfg_ff.rq_mask  <= 4'h0;
      end else if (csr_we) begin
         unique case (csr_index)
            REG_REQ_HDR:  cfg_ff.req_hdr  <= csr_wdata[0];
            REG_HDR_TEXT: cfg_ff.hdr_text <= csr_wdata;
            REG_HDR_LEN:  cfg_ff.hdr_len  <= csr_wdata[2:0];
            REG_EXP_VER:  cfg_ff.exp_ver  <= csr_wdata[15:0];
            REG_REQ_VER:  cfg_ff.req_ver  <= csr_wdata[0];
            REG_EN_MASK:  cfg_ff.en_mask  <= csr_wdata[3:0];
            REG_RQ_MASK:  cfg_ff.rq_mask  <= csr_wdata[3:0];
            default: ;
         endcase
      end
   end

   assign cfg = cfg_ff;

endmodule

// ----- hw/rtl/tkvp_parser.sv -----
// Parser core: packet and field state, per-byte update and end-of-packet verdict.
// Depends on tkvp_pkg.
`timescale 1ns / 1ps

module tkvp_parser (
   input  logic              clock,
   input  logic              reset,
   input  tkvp_pkg::cfg_type cfg,
   input  logic              step,
   input  logic [7:0]        payload_byte,
   input  logic              byte_present,
   input  logic              last_byte,
   output logic              res_valid,
   output tkvp_pkg::rsp_type res
);
   import tkvp_pkg::*;

   pkt_type pkt_ff;
   pkt_type pkt_in;
   pkt_type work;
   pkt_type fin;
   logic [3:0] reason;

   always_comb begin
      work = pkt_ff;
      if (byte_present) begin
         work.any_seen = 1'b1;
         if (pkt_ff.early == RSN_NONE) work = take_byte(work, cfg, payload_byte);
      end
      fin = work;
      if (work.early == RSN_NONE && !(work.ffp && !work.any_seen))
         fin = close_field(work, cfg);

      reason = fin.early;
      if (reason == RSN_NONE) begin
         if (cfg.req_ver && !fin.found[0]) begin
            reason = RSN_NO_VER;
         end else begin
            for (int i = 3; i >= 0; i--) begin
               if (cfg.rq_mask[i] && !fin.found[i+1]) reason = RSN_NO_SEQ + 4'(i);
            end
         end
         if (reason == RSN_NONE && fin.found[2] && fin.dneg) reason = RSN_DISTANCE;
         if (reason == RSN_NONE && fin.found[3] && fin.bnp) reason = RSN_BATTERY;
      end

      res.accepted            = (reason == RSN_NONE);
      res.reject_reason       = reason;
      res.version_found       = fin.found[0];
      res.version_value       = fin.caps[0];
      res.sequence_found      = fin.found[1];
      res.sequence_value      = fin.caps[1];
      res.distance_found      = fin.found[2];
      res.distance_hundredths = fin.caps[2];
      res.battery_found       = fin.found[3];
      res.battery_millivolts  = fin.caps[3];
      res.charging_found      = fin.found[4];
      res.charging_flag       = fin.chg;

      res_valid = step && last_byte;
      if (!step)          pkt_in = pkt_ff;
      else if (last_byte) pkt_in = pkt_clear();
      else                pkt_in = work;
   end

   always_ff @(posedge clock) begin
      if (reset) pkt_ff <= pkt_clear();
      else       pkt_ff <= pkt_in;
   end

endmodule

// ----- hw/rtl/telemetry_key_value_parser.sv -----
// Top level of the telemetry key=value packet parser.
// Depends on tkvp_pkg, tkvp_csr and tkvp_parser.
`timescale 1ns / 1ps

// The parser takes a text packet "header|key=value|..." one byte per transfer
// and returns one verdict transfer for each packet, launched by the transfer
// that carries tlast. A byte is taken every clock cycle unless stalled: each byte
// updates the field and packet trackers combinationally, and the verdict is
// held in one output register, so the bytes of a new packet are stalled while a
// verdict waits to be taken. The verdict appears in the cycle after the last byte.
// Input is stalled only while the output register is full and not being drained.
// Configuration registers are written through a simple write port, one
// register per cycle, and should be changed only while no packet is in flight.
module telemetry_key_value_parser (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [7:0]   req_tdata,   // payload_byte
   input  logic         req_tuser,   // byte_present
   input  logic         req_tlast,   // last_byte
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // accepted, reject_reason[4], version_found, version_value[32], sequence_found,
   // sequence_value[32], distance_found, distance_hundredths[32], battery_found,
   // battery_millivolts[32], charging_found, charging_flag, then zero fill
   output logic [143:0] rsp_tdata,
   input  logic         csr_we,
   input  logic [2:0]   csr_index,
   input  logic [31:0]  csr_wdata
);
   import tkvp_pkg::*;

   cfg_type cfg;
   logic    step;
   logic    res_valid;
   rsp_type res;
   rsp_type rsp_ff;
   logic    rsp_valid_ff;

   tkvp_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // The input side runs whenever the verdict register can take a new value.
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign step       = req_tvalid && req_tready;

   tkvp_parser u_parser (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg),
      .step         (step),
      .payload_byte (req_tdata),
      .byte_present (req_tuser),
      .last_byte    (req_tlast),
      .res_valid    (res_valid),
      .res          (res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_tready) begin
         rsp_valid_ff <= res_valid;
      end
   end

   // Payload register: loaded with each new verdict, no reset needed.
   always_ff @(posedge clock) begin
      if (req_tready && res_valid) begin
         rsp_ff <= res;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'd0, rsp_ff};

endmodule

// ----- hw/rtl/tkvp_checker.sv -----
// Port-level checks for the telemetry parser and the bind that attaches them.
// Depends on telemetry_key_value_parser.
`timescale 1ns / 1ps

module tkvp_checker (
   input logic         clock,
   input logic         reset,
   input logic         req_tvalid,
   input logic         req_tready,
   input logic         req_tlast,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [143:0] rsp_tdata
);

   // A held verdict stays put until it is taken.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("verdict changed while stalled");

   // The accepted flag agrees with a zero reject reason.
   a_acc: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[0] == (rsp_tdata[4:1] == 4'd0)))
      else $error("accepted flag disagrees with reason");

   // Reject reasons stay at or below 9, the highest defined code.
   a_rsn: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[4:1] <= 4'd9)
      else $error("undefined reject reason");

   // A fresh verdict follows a packet-ending input transfer.
   a_src: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !$past(rsp_tvalid) |-> $past(req_tvalid && req_tready && req_tlast))
      else $error("verdict without end of packet");

endmodule

bind telemetry_key_value_parser tkvp_checker u_tkvp_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tlast  (req_tlast),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
